// ===== design/refcounted_handle_table_unit_defines.svh =====
// Assertion macros used by the handle table top level.
`ifndef REFCOUNTED_HANDLE_TABLE_UNIT_DEFINES_SVH
`define REFCOUNTED_HANDLE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define RHTU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rhtu: assertion failed");
// Check on every clock edge, reset included.
`define RHTU_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rhtu: assertion failed");
`else
`define RHTU_ASSERT(lbl, prop)
`define RHTU_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== design/rhtu_pkg.sv =====
// Types and constants of the reference-counted handle table.
package rhtu_pkg;

	localparam int CMD_W        = 2;
	localparam int IDX_W        = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int COUNT_BITS   = 8;
	localparam int STATUS_W     = 3;
	localparam int NEW_IDX_W    = 8;

	localparam int IN_FIELDS_W  = CMD_W + IDX_W + PAYLOAD_BITS;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + NEW_IDX_W + PAYLOAD_BITS + COUNT_BITS + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_FETCH  = 2'd2,
		CMD_DROP   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_RANGE = 3'd2,
		ST_EMPTY = 3'd3,
		ST_SAT   = 3'd4
	} status_t;

	// Classified command as it sits in the queue.
	typedef struct packed {
		cmd_t                    cmd;
		logic [IDX_W-1:0]        slot_index;
		logic                    beyond;     // negative or past the table
		logic [PAYLOAD_BITS-1:0] payload;
	} item_t;

	typedef struct packed {
		status_t                 status;
		logic [NEW_IDX_W-1:0]    new_index;
		logic [PAYLOAD_BITS-1:0] payload_out;
		logic [COUNT_BITS-1:0]   count_after;
		logic                    old_released;
	} result_t;

endpackage

// ===== design/rhtu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rhtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rhtu_front.sv =====
// Front end: accept commands, flag bad indexes, hold them in a two-entry queue.
module rhtu_front
	import rhtu_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept_en,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  cmd_t                    in_cmd,
	input  logic [IDX_W-1:0]        in_slot_index,
	input  logic [PAYLOAD_BITS-1:0] in_payload,
	output logic                    q_valid,
	input  logic                    q_ready,
	output item_t                   q_item
);

	localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(TABLE_DEPTH);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	item_t      item_d;
	logic       push;
	logic       pop;

	// Negative indexes and those past the table never address a slot.
	always_comb begin
		item_d.cmd        = in_cmd;
		item_d.slot_index = in_slot_index;
		item_d.beyond     = in_slot_index[IDX_W-1] ||
		                    ({1'b0, in_slot_index} >= DEPTH_EXT);
		item_d.payload    = in_payload;
	end

	assign in_ready = (fill_q != 2'd2) && accept_en;
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_d;
		end
	end

endmodule

// ===== design/rhtu_back.sv =====
// Back end: table memories, allocation pointers and command execution.
module rhtu_back
	import rhtu_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	output logic    q_ready,
	input  item_t   q_item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res,
	output logic    clearing
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int HW = $clog2(TABLE_DEPTH + 1);
	localparam logic [HW-1:0] DEPTH_HW = HW'(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CHK
	} state_t;

	state_t  state_q;
	logic [HW-1:0] hw_q;
	logic [HW-1:0] free_q;
	logic [HW-1:0] scan_q;
	logic [IW-1:0] clr_q;
	item_t   item_q;
	logic    res_valid_q;
	result_t res_q;

	logic                    cnt_we;
	logic [IW-1:0]           cnt_wa;
	logic [COUNT_BITS-1:0]   cnt_wd;
	logic [IW-1:0]           cnt_ra;
	logic [COUNT_BITS-1:0]   cnt_rd;
	logic                    pl_we;
	logic [PAYLOAD_BITS-1:0] pl_rd;

	logic [IW-1:0] idx;
	logic [IW-1:0] slot;
	logic          in_range;
	result_t       res_d;
	logic [HW-1:0] hw_d;
	logic [HW-1:0] free_d;
	logic [HW-1:0] scan_d;
	logic          go_scan;

	rhtu_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_wa),
		.wdata (cnt_wd),
		.raddr (cnt_ra),
		.rdata (cnt_rd)
	);

	rhtu_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_payload_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (slot),
		.wdata (item_q.payload),
		.raddr (q_item.slot_index[IW-1:0]),
		.rdata (pl_rd)
	);

	assign q_ready   = (state_q == S_IDLE) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign clearing  = (state_q == S_CLEAR);
	assign idx       = item_q.slot_index[IW-1:0];
	assign in_range  = !item_q.beyond &&
	                   ({1'b0, item_q.slot_index} < (IDX_W + 1)'(hw_q));
	assign cnt_ra    = (state_q == S_SCAN_RD) ? scan_q[IW-1:0]
	                                          : q_item.slot_index[IW-1:0];

	// Execute the held command against the count and payload just read.
	// A used slot always has a nonzero count, so count zero means free.
	always_comb begin
		res_d       = '0;
		res_d.status = ST_OK;
		hw_d        = hw_q;
		free_d      = free_q;
		scan_d      = scan_q;
		go_scan     = 1'b0;
		slot        = idx;
		cnt_we      = 1'b0;
		cnt_wd      = '0;
		pl_we       = 1'b0;

		if (state_q == S_EXEC) begin
			if (item_q.cmd == CMD_CREATE) begin
				if (free_q < hw_q) begin
					// Reuse the lowest hole; find the next one afterwards.
					slot = free_q[IW-1:0];
					if (free_q + 1'b1 == hw_q) begin
						free_d = hw_q;
					end else begin
						go_scan = 1'b1;
						scan_d  = free_q + 1'b1;
					end
				end else if (hw_q < DEPTH_HW) begin
					slot   = hw_q[IW-1:0];
					hw_d   = hw_q + 1'b1;
					free_d = hw_q + 1'b1;
				end else begin
					res_d.status = ST_FULL;
				end
				if (res_d.status == ST_OK) begin
					cnt_we            = 1'b1;
					cnt_wd            = COUNT_BITS'(1);
					pl_we             = 1'b1;
					res_d.new_index   = NEW_IDX_W'(slot);
					res_d.count_after = COUNT_BITS'(1);
				end
			end else if (!in_range) begin
				res_d.status = ST_RANGE;
			end else if (cnt_rd == '0) begin
				res_d.status = ST_EMPTY;
			end else begin
				case (item_q.cmd)
					CMD_UPDATE: begin
						cnt_we             = 1'b1;
						cnt_wd             = COUNT_BITS'(1);
						pl_we              = 1'b1;
						res_d.count_after  = COUNT_BITS'(1);
						res_d.old_released = (cnt_rd <= COUNT_BITS'(1));
					end
					CMD_FETCH: begin
						if (cnt_rd == COUNT_MAX) begin
							res_d.status      = ST_SAT;
							res_d.count_after = cnt_rd;
						end else begin
							cnt_we            = 1'b1;
							cnt_wd            = cnt_rd + 1'b1;
							res_d.count_after = cnt_rd + 1'b1;
							res_d.payload_out = pl_rd;
						end
					end
					CMD_DROP: begin
						cnt_we            = 1'b1;
						cnt_wd            = cnt_rd - 1'b1;
						res_d.count_after = cnt_rd - 1'b1;
						if (cnt_rd == COUNT_BITS'(1)) begin
							res_d.old_released = 1'b1;
							if (HW'(idx) < free_q) begin
								free_d = HW'(idx);
							end
						end
					end
					default: begin
						res_d.status = ST_OK;
					end
				endcase
			end
		end

		cnt_wa = slot;
		if (state_q == S_CLEAR) begin
			cnt_we = 1'b1;
			cnt_wa = clr_q;
			cnt_wd = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			hw_q        <= '0;
			free_q      <= '0;
			scan_q      <= '0;
			clr_q       <= '0;
			item_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid && q_ready) begin
						item_q  <= q_item;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_valid_q <= 1'b1;
					res_q       <= res_d;
					hw_q        <= hw_d;
					free_q      <= free_d;
					scan_q      <= scan_d;
					state_q     <= go_scan ? S_SCAN_RD : S_IDLE;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (cnt_rd == '0) begin
						free_q  <= scan_q;
						state_q <= S_IDLE;
					end else if (scan_q + 1'b1 == hw_q) begin
						free_q  <= hw_q;
						state_q <= S_IDLE;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/refcounted_handle_table_unit.sv =====
// Top level of the reference-counted handle table with lowest-free allocation.
//
//   Channel   Dir  Fields (lowest bit first)
//   s_*       in   cmd[1:0], slot_index[17:2], payload_in[49:18], zero pad to 56
//   m_*       out  status[2:0], new_index[10:3], payload_out[42:11],
//                  count_after[50:43], old_released[51], zero pad to 56
//
// Each command holds the back end for a memory read, then an execute and write-back
// step, so the back end takes no new command until it is through with the last. A
// create into a recycled slot then scans for the next hole, reading then checking
// each slot, up to TABLE_DEPTH - 1 slots. After reset a clearing pass zeroes every
// count with s_tready low. A stalled m_tready holds the result and, once the
// two-entry queue fills, s_tready.
`include "refcounted_handle_table_unit_defines.svh"

module refcounted_handle_table_unit
	import rhtu_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // cmd, slot_index, payload_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // status, new_index, payload_out,
	                                         // count_after, old_released
);

	logic    q_valid;
	logic    q_ready;
	item_t   q_item;
	logic    clearing;
	result_t res;
	logic    q_fire;

	// Front: classify each transfer and queue it.
	rhtu_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept_en     (!clearing),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_cmd        (cmd_t'(s_tdata[CMD_W-1:0])),
		.in_slot_index (s_tdata[CMD_W +: IDX_W]),
		.in_payload    (s_tdata[CMD_W + IDX_W +: PAYLOAD_BITS]),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item)
	);

	// Back: run one command at a time against the table.
	rhtu_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res),
		.clearing  (clearing)
	);

	// Pack result fields from the lowest bit up; pad with zeros.
	assign m_tdata = OUT_TDATA_W'({res.old_released, res.count_after, res.payload_out,
	                               res.new_index, res.status});

	assign q_fire = q_valid && q_ready;

	// No command enters while the count memory is being cleared.
	`RHTU_ASSERT(a_no_accept_clearing, (s_tvalid && s_tready) |-> !clearing)
	// The queue stays empty through reset and the clearing pass.
	`RHTU_ASSERT_ALWAYS(a_queue_empty_clearing, clearing |-> !q_valid)
	// A fresh result follows a queue pop through the execute state and the result register.
	`RHTU_ASSERT(a_result_after_pop, $rose(m_tvalid) |-> $past(q_fire, 2))

endmodule
